@@ src/segint_pkg.sv @@
// Package with the per-item flag type of the segment intersection block.
`default_nettype none

package segint_pkg;

   // Per-item flags that travel beside the division pipeline.
   typedef struct packed {
      logic hit;
      logic point_valid;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
   } side_type;

endpackage

`default_nettype wire

@@ src/segint_if.sv @@
// Valid/ready channel interfaces for segment pairs and crossing results.
`default_nettype none

interface segint_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_start_x;
   logic signed [COORD_BITS-1:0] a_start_y;
   logic signed [COORD_BITS-1:0] a_end_x;
   logic signed [COORD_BITS-1:0] a_end_y;
   logic signed [COORD_BITS-1:0] b_start_x;
   logic signed [COORD_BITS-1:0] b_start_y;
   logic signed [COORD_BITS-1:0] b_end_x;
   logic signed [COORD_BITS-1:0] b_end_y;

   modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, input ready);
   modport sink   (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface segint_rsp_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic                         point_valid;
   logic signed [COORD_BITS-1:0] cross_x;
   logic signed [COORD_BITS-1:0] cross_y;
   logic                         point_clipped;

   modport source (output valid, hit, point_valid, cross_x, cross_y, point_clipped,
                   input ready);
   modport sink   (input valid, hit, point_valid, cross_x, cross_y, point_clipped,
                   output ready);
endinterface

`default_nettype wire

@@ src/segment_intersection.sv @@
// Top level: pipelined 2-D segment intersection with restoring dividers.
`default_nettype none

// Takes one segment pair per cycle while the output is not stalled and returns one
// result per pair, in order. An item passes through six arithmetic stages
// (differences, determinant products, determinants, split numerator products,
// numerator sums, magnitudes), one range check, one restoring division stage
// per quotient bit (COORD_BITS + 1 of them, one compare and subtract each),
// a rounding stage and the output register. The whole pipeline holds while a
// result waits on the output, so req_port.ready follows rsp_port.ready.
module segment_intersection #(
   parameter int COORD_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   segint_req_if.sink   req_port,
   segint_rsp_if.source rsp_port
);
   import segint_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int DW = C + 1;        // coordinate difference
   localparam int PW = 2 * C + 2;    // difference product
   localparam int KW = 2 * C + 3;    // determinant and numerators
   localparam int LW = C + 2;        // low split of a determinant
   localparam int HW = KW - LW;      // high split of a determinant
   localparam int NW = 3 * C + 4;    // crossing numerator
   localparam int QW = C + 1;        // quotient bits

   logic adv;
   assign adv            = !rsp_port.valid || rsp_port.ready;
   assign req_port.ready = adv;

   // Stage 1: coordinate differences.
   logic                 v1_ff;
   logic signed [DW-1:0] dx12_ff, dy12_ff, dx34_ff, dy34_ff, dx13_ff, dy13_ff;
   logic signed [DW-1:0] ax1_ff, ay1_ff;
   logic signed [C-1:0]  x1_1_ff, y1_1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dx12_ff <= DW'(req_port.a_start_x) - DW'(req_port.a_end_x);
         dy12_ff <= DW'(req_port.a_start_y) - DW'(req_port.a_end_y);
         dx34_ff <= DW'(req_port.b_start_x) - DW'(req_port.b_end_x);
         dy34_ff <= DW'(req_port.b_start_y) - DW'(req_port.b_end_y);
         dx13_ff <= DW'(req_port.a_start_x) - DW'(req_port.b_start_x);
         dy13_ff <= DW'(req_port.a_start_y) - DW'(req_port.b_start_y);
         ax1_ff  <= DW'(req_port.a_end_x) - DW'(req_port.a_start_x);
         ay1_ff  <= DW'(req_port.a_end_y) - DW'(req_port.a_start_y);
         x1_1_ff <= req_port.a_start_x;
         y1_1_ff <= req_port.a_start_y;
      end
   end

   // Stage 2: the six determinant products.
   logic                 v2_ff;
   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   logic signed [DW-1:0] ax2_ff, ay2_ff;
   logic signed [C-1:0]  x1_2_ff, y1_2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff   <= PW'(dx12_ff) * PW'(dy34_ff);
         pb_ff   <= PW'(dy12_ff) * PW'(dx34_ff);
         pc_ff   <= PW'(dx13_ff) * PW'(dy34_ff);
         pd_ff   <= PW'(dy13_ff) * PW'(dx34_ff);
         pe_ff   <= PW'(dy12_ff) * PW'(dx13_ff);
         pf_ff   <= PW'(dx12_ff) * PW'(dy13_ff);
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         x1_2_ff <= x1_1_ff;
         y1_2_ff <= y1_1_ff;
      end
   end

   // Stage 3: determinant and the two position numerators.
   logic                 v3_ff;
   logic signed [KW-1:0] d3_ff, t3_ff, u3_ff;
   logic signed [DW-1:0] ax3_ff, ay3_ff;
   logic signed [C-1:0]  x1_3_ff, y1_3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         d3_ff   <= KW'(pa_ff) - KW'(pb_ff);
         t3_ff   <= KW'(pc_ff) - KW'(pd_ff);
         u3_ff   <= KW'(pe_ff) - KW'(pf_ff);
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
         x1_3_ff <= x1_2_ff;
         y1_3_ff <= y1_2_ff;
      end
   end

   // Stage 4: hit test on sign-normalized values, split numerator products.
   logic signed [KW-1:0] dpos, tpos, upos;
   logic signed [LW:0]   dlo, tlo;
   logic signed [HW-1:0] dhi, thi;

   always_comb begin
      dpos = d3_ff[KW-1] ? -d3_ff : d3_ff;
      tpos = d3_ff[KW-1] ? -t3_ff : t3_ff;
      upos = d3_ff[KW-1] ? -u3_ff : u3_ff;
      dlo  = $signed({1'b0, d3_ff[LW-1:0]});
      tlo  = $signed({1'b0, t3_ff[LW-1:0]});
      dhi  = $signed(d3_ff[KW-1:LW]);
      thi  = $signed(t3_ff[KW-1:LW]);
   end

   logic                      v4_ff, hit4_ff, pv4_ff, dneg4_ff;
   logic [KW-1:0]             dmag4_ff;
   logic signed [C+LW:0]      mxl_ff, myl_ff;
   logic signed [C+HW-1:0]    mxh_ff, myh_ff;
   logic signed [DW+LW:0]     mal_ff, mbl_ff;
   logic signed [DW+HW-1:0]   mah_ff, mbh_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         hit4_ff  <= (tpos > 0) && (tpos < dpos) && (upos > 0) && (upos < dpos);
         pv4_ff   <= (d3_ff != '0);
         dneg4_ff <= d3_ff[KW-1];
         dmag4_ff <= dpos;
         mxl_ff   <= (C+LW+1)'(x1_3_ff) * (C+LW+1)'(dlo);
         mxh_ff   <= (C+HW)'(x1_3_ff) * (C+HW)'(dhi);
         myl_ff   <= (C+LW+1)'(y1_3_ff) * (C+LW+1)'(dlo);
         myh_ff   <= (C+HW)'(y1_3_ff) * (C+HW)'(dhi);
         mal_ff   <= (DW+LW+1)'(ax3_ff) * (DW+LW+1)'(tlo);
         mah_ff   <= (DW+HW)'(ax3_ff) * (DW+HW)'(thi);
         mbl_ff   <= (DW+LW+1)'(ay3_ff) * (DW+LW+1)'(tlo);
         mbh_ff   <= (DW+HW)'(ay3_ff) * (DW+HW)'(thi);
      end
   end

   // Stage 5: crossing numerators x1*d + (x2-x1)*t and the same for y.
   logic                 v5_ff, hit5_ff, pv5_ff, dneg5_ff;
   logic [KW-1:0]        dmag5_ff;
   logic signed [NW-1:0] xn_ff, yn_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         xn_ff    <= (NW'(mxh_ff) <<< LW) + NW'(mxl_ff) + (NW'(mah_ff) <<< LW) + NW'(mal_ff);
         yn_ff    <= (NW'(myh_ff) <<< LW) + NW'(myl_ff) + (NW'(mbh_ff) <<< LW) + NW'(mbl_ff);
         hit5_ff  <= hit4_ff;
         pv5_ff   <= pv4_ff;
         dneg5_ff <= dneg4_ff;
         dmag5_ff <= dmag4_ff;
      end
   end

   // Stage 6: numerator magnitudes and quotient signs.
   logic          v6_ff, hit6_ff, pv6_ff, negx6_ff, negy6_ff;
   logic [KW-1:0] dmag6_ff;
   logic [NW-1:0] mx6_ff, my6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mx6_ff   <= xn_ff[NW-1] ? -xn_ff : xn_ff;
         my6_ff   <= yn_ff[NW-1] ? -yn_ff : yn_ff;
         negx6_ff <= xn_ff[NW-1] ^ dneg5_ff;
         negy6_ff <= yn_ff[NW-1] ^ dneg5_ff;
         hit6_ff  <= hit5_ff;
         pv6_ff   <= pv5_ff;
         dmag6_ff <= dmag5_ff;
      end
   end

   // Stage 7: a quotient of 2^QW or more saturates for certain.
   logic          vd_ff [QW+1];
   logic [NW-1:0] rx_ff [QW+1];
   logic [NW-1:0] ry_ff [QW+1];
   logic [QW-1:0] qx_ff [QW+1];
   logic [QW-1:0] qy_ff [QW+1];
   logic [KW-1:0] dm_ff [QW+1];
   side_type      sd_ff [QW+1];
   logic [NW-1:0] dtop;

   assign dtop = {dmag6_ff, {QW{1'b0}}};

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff[0]             <= mx6_ff;
         ry_ff[0]             <= my6_ff;
         qx_ff[0]             <= '0;
         qy_ff[0]             <= '0;
         dm_ff[0]             <= dmag6_ff;
         sd_ff[0].hit         <= hit6_ff;
         sd_ff[0].point_valid <= pv6_ff;
         sd_ff[0].neg_x       <= negx6_ff;
         sd_ff[0].neg_y       <= negy6_ff;
         sd_ff[0].ovf_x       <= (mx6_ff >= dtop);
         sd_ff[0].ovf_y       <= (my6_ff >= dtop);
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar k = 0; k < QW; k++) begin : g_div
      localparam int B = QW - 1 - k;
      logic [NW-1:0] sub;
      assign sub = NW'(dm_ff[k]) << B;

      always_ff @(posedge clock) begin
         if (adv) begin
            if (rx_ff[k] >= sub) begin
               rx_ff[k+1] <= rx_ff[k] - sub;
               qx_ff[k+1] <= qx_ff[k] | (QW'(1) << B);
            end else begin
               rx_ff[k+1] <= rx_ff[k];
               qx_ff[k+1] <= qx_ff[k];
            end
            if (ry_ff[k] >= sub) begin
               ry_ff[k+1] <= ry_ff[k] - sub;
               qy_ff[k+1] <= qy_ff[k] | (QW'(1) << B);
            end else begin
               ry_ff[k+1] <= ry_ff[k];
               qy_ff[k+1] <= qy_ff[k];
            end
            dm_ff[k+1] <= dm_ff[k];
            sd_ff[k+1] <= sd_ff[k];
         end
      end
   end

   // Rounding stage: half or more of the divisor rounds the magnitude up.
   logic          vr_ff;
   logic [QW:0]   magx_ff, magy_ff;
   side_type      sr_ff;
   logic          incx, incy;

   assign incx = {rx_ff[QW][KW-1:0], 1'b0} >= {1'b0, dm_ff[QW]};
   assign incy = {ry_ff[QW][KW-1:0], 1'b0} >= {1'b0, dm_ff[QW]};

   always_ff @(posedge clock) begin
      if (adv) begin
         magx_ff <= {1'b0, qx_ff[QW]} + (QW+1)'(incx);
         magy_ff <= {1'b0, qy_ff[QW]} + (QW+1)'(incy);
         sr_ff   <= sd_ff[QW];
      end
   end

   // Output stage: apply the sign and saturate to the coordinate range.
   logic [QW:0]         lim_neg, lim_pos;
   logic                clipx, clipy;
   logic signed [C-1:0] cx, cy;
   logic signed [C-1:0] c_max, c_min;

   always_comb begin
      lim_neg = (QW+1)'(1) << (C - 1);
      lim_pos = lim_neg - (QW+1)'(1);
      c_max   = {1'b0, {(C-1){1'b1}}};
      c_min   = {1'b1, {(C-1){1'b0}}};
      clipx   = sr_ff.ovf_x || (sr_ff.neg_x ? (magx_ff > lim_neg) : (magx_ff > lim_pos));
      clipy   = sr_ff.ovf_y || (sr_ff.neg_y ? (magy_ff > lim_neg) : (magy_ff > lim_pos));
      if (clipx) begin
         cx = sr_ff.neg_x ? c_min : c_max;
      end else begin
         cx = sr_ff.neg_x ? -$signed(magx_ff[C-1:0]) : $signed(magx_ff[C-1:0]);
      end
      if (clipy) begin
         cy = sr_ff.neg_y ? c_min : c_max;
      end else begin
         cy = sr_ff.neg_y ? -$signed(magy_ff[C-1:0]) : $signed(magy_ff[C-1:0]);
      end
   end

   logic                vo_ff, hit_ff, pv_ff, clip_ff;
   logic signed [C-1:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (sr_ff.point_valid) begin
            hit_ff  <= sr_ff.hit;
            pv_ff   <= 1'b1;
            cx_ff   <= cx;
            cy_ff   <= cy;
            clip_ff <= clipx || clipy;
         end else begin
            hit_ff  <= 1'b0;
            pv_ff   <= 1'b0;
            cx_ff   <= '0;
            cy_ff   <= '0;
            clip_ff <= 1'b0;
         end
      end
   end

   // Valid bits march with the data; the whole pipeline holds on a stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         for (int i = 0; i <= QW; i++) begin
            vd_ff[i] <= 1'b0;
         end
         vr_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req_port.valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         v6_ff    <= v5_ff;
         vd_ff[0] <= v6_ff;
         for (int i = 0; i < QW; i++) begin
            vd_ff[i+1] <= vd_ff[i];
         end
         vr_ff <= vd_ff[QW];
         vo_ff <= vr_ff;
      end
   end

   assign rsp_port.valid         = vo_ff;
   assign rsp_port.hit           = hit_ff;
   assign rsp_port.point_valid   = pv_ff;
   assign rsp_port.cross_x       = cx_ff;
   assign rsp_port.cross_y       = cy_ff;
   assign rsp_port.point_clipped = clip_ff;

endmodule

`default_nettype wire
